// ----- design/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and command codes for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SCOPE = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] block_offset;
        logic [6:0] block_size;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [15:0] address;
    } t_out_item;

endpackage

// ----- design/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// One-bit-wide synchronous RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);
    logic mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- design/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clearing pass, first-fit search, run marking, hint rescan,
// run free and scope copy over the two bitmap RAMs.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int HEAP_WORDS = 1024,
    parameter int MAX_RUN    = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int PW = AW + 1;
    localparam int SW = ((PW > 7) ? PW : 7) + 1;
    localparam logic [SW-1:0] HEAP_END = SW'(HEAP_WORDS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_MARK  = 4'd4;
    localparam logic [3:0] S_HRD   = 4'd5;
    localparam logic [3:0] S_HCHK  = 4'd6;
    localparam logic [3:0] S_FREE  = 4'd7;
    localparam logic [3:0] S_CRD   = 4'd8;
    localparam logic [3:0] S_CWR   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_end, n_end;
    logic [PW-1:0] r_hint, n_hint;
    logic [6:0]    r_size, n_size;
    logic          r_status, n_status;
    logic [15:0]   r_base;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    // address is only meaningful for a successful allocation; latched aside
    logic          r_is_alloc, n_is_alloc;

    logic          use_we, use_wd, ever_we, use_rd, ever_rd;
    logic [SW-1:0] pos_w, start_w, run_end, free_end, clip;
    logic [15:0]   start16;

    ffba_ram #(.DEPTH(HEAP_WORDS), .AW(AW)) u_use (
        .i_clk(i_clk), .i_we(use_we), .i_waddr(r_pos[AW-1:0]), .i_wdata(use_wd),
        .i_raddr(r_pos[AW-1:0]), .o_rdata(use_rd)
    );
    ffba_ram #(.DEPTH(HEAP_WORDS), .AW(AW)) u_ever (
        .i_clk(i_clk), .i_we(ever_we), .i_waddr(r_pos[AW-1:0]),
        .i_wdata(r_state != S_CLEAR), .i_raddr(r_pos[AW-1:0]), .o_rdata(ever_rd)
    );

    assign pos_w   = SW'(r_pos);
    assign start_w = SW'(r_start);
    assign run_end = start_w + SW'(r_size);
    assign clip    = (32'(r_size) > MAX_RUN) ? SW'(MAX_RUN) : SW'(r_size);
    assign start16 = 16'(r_start);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_start     = r_start;
        n_end       = r_end;
        n_hint      = r_hint;
        n_size      = r_size;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        use_we      = 1'b0;
        use_wd      = 1'b0;
        ever_we     = 1'b0;
        free_end    = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                if (pos_w >= HEAP_END) begin
                    n_state = S_IDLE;
                end else begin
                    use_we  = 1'b1;
                    ever_we = 1'b1;
                    n_pos   = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_size   = i_in_item.block_size;
                    n_status = 1'b0;
                    n_start  = '0;
                    case (i_in_item.cmd)
                        CMD_ALLOC: begin
                            if (32'(i_in_item.block_size) > MAX_RUN) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else begin
                                n_start = r_hint;
                                n_pos   = r_hint;
                                n_state = S_SRD;
                            end
                        end
                        CMD_FREE: begin
                            if (32'(i_in_item.block_offset) >= HEAP_WORDS) begin
                                n_state = S_DONE;
                            end else begin
                                n_pos = PW'(i_in_item.block_offset);
                                if (PW'(i_in_item.block_offset) < r_hint) begin
                                    n_hint = PW'(i_in_item.block_offset);
                                end
                                n_state = S_FREE;
                                n_end   = '0;
                            end
                        end
                        CMD_SCOPE: begin
                            n_pos   = '0;
                            n_state = S_CRD;
                        end
                        default: n_state = S_DONE;
                    endcase
                    if (i_in_item.cmd == CMD_FREE) begin
                        n_size = i_in_item.block_size;
                    end
                end
            end
            S_SRD: begin
                if (start_w >= HEAP_END || run_end > HEAP_END) begin
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end else if (pos_w == run_end) begin
                    n_pos   = r_start;
                    n_state = S_MARK;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (use_rd) begin
                    n_start = r_pos + 1'b1;
                end
                n_pos   = r_pos + 1'b1;
                n_state = S_SRD;
            end
            S_MARK: begin
                if (pos_w == run_end) begin
                    if (r_start == r_hint) begin
                        n_pos   = r_hint;
                        n_state = S_HRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    use_we  = 1'b1;
                    use_wd  = 1'b1;
                    ever_we = 1'b1;
                    n_pos   = r_pos + 1'b1;
                end
            end
            S_HRD: begin
                if (pos_w >= HEAP_END) begin
                    n_hint  = PW'(HEAP_WORDS);
                    n_state = S_DONE;
                end else begin
                    n_state = S_HCHK;
                end
            end
            S_HCHK: begin
                if (!use_rd) begin
                    n_hint  = r_pos;
                    n_state = S_DONE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_HRD;
                end
            end
            S_FREE: begin
                // end of run: offset + clipped size, capped at heap end
                free_end = start_w + clip;
                if (r_end == '0) begin
                    // first cycle: latch offset as run origin
                    n_start = r_pos;
                    n_end   = '1;
                end else if (free_end <= pos_w || pos_w >= HEAP_END) begin
                    n_state = S_DONE;
                end else begin
                    use_we = 1'b1;
                    n_pos  = r_pos + 1'b1;
                end
            end
            S_CRD: begin
                if (pos_w >= HEAP_END) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                use_we  = 1'b1;
                use_wd  = ever_rd;
                n_pos   = r_pos + 1'b1;
                n_state = S_CRD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = r_status;
                    n_out.address  = (r_is_alloc && !r_status) ? (r_base + start16)
                                                               : 16'd0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_is_alloc = r_is_alloc;
        if (r_state == S_IDLE && i_in_valid) begin
            n_is_alloc = (i_in_item.cmd == CMD_ALLOC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_hint      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
            r_is_alloc  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
            r_is_alloc  <= n_is_alloc;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_end    <= n_end;
        r_size   <= n_size;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_hint) <= HEAP_END) else $error("hint beyond heap end");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_w <= HEAP_END) else $error("scan position beyond heap end");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> (r_out.address == 16'd0))
        else $error("failed allocation with nonzero address");
endmodule

// ----- design/first_fit_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_top
// First-fit contiguous word allocator over in-use and ever-used bitmaps.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------
//  in      | i_in_valid   | o_in_stall   | i_in_item  (cmd/offset/size)
//  out     | o_out_valid  | i_out_stall  | o_out_item (status/address)
//  config  | i_cfg_we     | -            | i_cfg_wdata (base_address)
//
// Sequencing: one item at a time; both bitmaps are 1-bit RAMs walked one
//   word per access. After the accept cycle: allocate checks words for a
//   free run, then marks it, then (only if the run starts at the hint)
//   rescans used words for a new hint, then stores; oversized/undefined
//   store directly; free clears the clipped run; new scope copies maps.
// Reset: a clearing pass zeroes both maps; input is stalled meanwhile,
//   config writes are taken.
// Stalls: input is stalled from accept until the result is stored. A
//   finished result waits in the output register while the next item is
//   accepted; it only blocks completion of that next item.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator_top
    import ffba_pkg::*;
#(
    parameter int HEAP_WORDS = 1024,
    parameter int MAX_RUN    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);
    ffba_ctrl #(.HEAP_WORDS(HEAP_WORDS), .MAX_RUN(MAX_RUN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );
endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap allocator: a predictor keeps
// its own bitmaps, hint and base address, and each result item is compared
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    import ffba_pkg::*;

    localparam int HEAP    = 1024;
    localparam int RUN_MAX = 64;
    localparam logic [1:0] CMD_UNDEF = 2'd3;
    localparam longint CYCLE_LIMIT = 20000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    first_fit_bitmap_allocator_top #(.HEAP_WORDS(HEAP), .MAX_RUN(RUN_MAX)) DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit          busy_map [HEAP];
    bit          touched_map [HEAP];
    int unsigned free_hint;
    logic [15:0] heap_base;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int        fail_count = 0;
    bit        quiet_tail = 1'b0;   // no idling in the last part of the run
    bit        hold_output = 1'b0;  // long receiver hold-off requested
    int        hold_cycles = 0;
    longint    cycle_count = 0;

    // stall seen at the last rising edge, so the driver knows what was taken
    logic o_in_stall_q = 1'b1;

    function automatic int unsigned first_clear_from(int unsigned from);
        for (int unsigned i = from; i < HEAP; i++)
            if (!busy_map[i]) return i;
        return HEAP;
    endfunction

    // Computes the result of one item and updates the predictor state.
    function automatic t_out_item allocator_result(t_in_item it);
        t_out_item   r;
        int unsigned sz;
        int unsigned start;
        int unsigned lim;
        bit          fits;
        bit          found;
        r = '0;
        sz = it.block_size;
        found = 1'b0;
        case (it.cmd)
            CMD_ALLOC: begin
                if (sz <= RUN_MAX) begin
                    start = free_hint;
                    while (!found && start < HEAP && start + sz <= HEAP) begin
                        fits = 1'b1;
                        for (int unsigned i = start; i < start + sz; i++) begin
                            if (busy_map[i]) begin
                                fits = 1'b0;
                                start = i + 1;
                                break;
                            end
                        end
                        if (fits) found = 1'b1;
                    end
                end
                if (found) begin
                    for (int unsigned i = start; i < start + sz; i++) begin
                        busy_map[i] = 1'b1;
                        touched_map[i] = 1'b1;
                    end
                    if (start == free_hint) free_hint = first_clear_from(free_hint);
                    r.address = heap_base + 16'(start);
                end else begin
                    r.status = 1'b1;
                end
            end
            CMD_FREE: begin
                lim = (sz > RUN_MAX) ? RUN_MAX : sz;
                for (int unsigned i = it.block_offset;
                     i < it.block_offset + lim && i < HEAP; i++)
                    busy_map[i] = 1'b0;
                if (it.block_offset < free_hint) free_hint = it.block_offset;
            end
            CMD_SCOPE: busy_map = touched_map;
            default: ;
        endcase
        return r;
    endfunction

    // driver: offers queued items, random idle bursts
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_q) begin
                // item went at the last rising edge
                if (!quiet_tail && send_gap == 0 && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 5);
                if (send_gap == 0 && pending_items.size() > 0) begin
                    i_in_item <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (send_gap > 0) send_gap--;
                else if (pending_items.size() > 0) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
            if (send_gap > 0 && i_in_valid && !o_in_stall_q) send_gap--;
        end
    end

    // receiver stall, in bursts or one long hold-off
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else if (hold_output) begin
            hold_output <= 1'b0;
            hold_cycles <= 300;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        cycle_count++;
        o_in_stall_q <= o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pred = allocator_result(i_in_item);
                expected_results = {expected_results, pred};
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item status=%0b address=%h",
                             $time, o_out_item.status, o_out_item.address);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, o_out_item.status);
                        fail_count++;
                    end
                    if (o_out_item.address !== want.address) begin
                        $display("%0t: address expected %h actual %h",
                                 $time, want.address, o_out_item.address);
                        fail_count++;
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_bitmap_allocator_top: mismatch");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [1:0] c, int offs, int sz);
        t_in_item it;
        it.cmd = c;
        it.block_offset = 10'(offs);
        it.block_size = 7'(sz);
        return it;
    endfunction

    // appends one item to the send queue
    function automatic void queue_item(t_in_item it);
        pending_items = {pending_items, it};
    endfunction

    // waits until every item is sent and answered, then lets the block settle
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2 * HEAP + 200) @(posedge i_clk);
    endtask

    task automatic write_base(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        heap_base = v;
    endtask

    // mostly allocations of small runs, frees of plausible runs
    task automatic random_phase(int count);
        int k;
        int r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                queue_item(make_item(CMD_ALLOC, $urandom_range(0, 1023),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 24)));
            else if (r < 90)
                queue_item(make_item(CMD_FREE,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 300),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 32)));
            else if (r < 96)
                queue_item(make_item(CMD_SCOPE, $urandom_range(0, 1023),
                                     $urandom_range(0, 127)));
            else
                queue_item(make_item(CMD_UNDEF, $urandom_range(0, 1023),
                                     $urandom_range(0, 127)));
        end
    endtask

    initial begin
        for (int i = 0; i < HEAP; i++) begin
            busy_map[i] = 1'b0;
            touched_map[i] = 1'b0;
        end
        free_hint = 0;
        heap_base = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_base(16'h0000);

        // directed: extremes, every command, the corner cases
        queue_item(make_item(CMD_ALLOC, 0, 0));       // zero size
        queue_item(make_item(CMD_ALLOC, 1023, 64));   // largest run
        queue_item(make_item(CMD_ALLOC, 0, 65));      // oversized
        queue_item(make_item(CMD_ALLOC, 0, 127));
        queue_item(make_item(CMD_ALLOC, 0, 1));
        queue_item(make_item(CMD_FREE, 0, 0));        // free of zero words
        queue_item(make_item(CMD_ALLOC, 0, 3));       // hint on a used word
        queue_item(make_item(CMD_FREE, 10, 127));     // oversized free
        queue_item(make_item(CMD_SCOPE, 0, 0));       // restore ever-used
        queue_item(make_item(CMD_FREE, 1023, 64));    // free past heap end
        queue_item(make_item(CMD_UNDEF, 1023, 127));
        for (int i = 0; i < 16; i++)                  // 64-word runs until none fits
            queue_item(make_item(CMD_ALLOC, 0, 64));
        drain();
        write_base(16'hFFFF);
        queue_item(make_item(CMD_ALLOC, 0, 1));       // one word in the free tail
        queue_item(make_item(CMD_FREE, 1000, 30));
        queue_item(make_item(CMD_ALLOC, 0, 30));      // fits in the free tail
        queue_item(make_item(CMD_ALLOC, 0, 24));      // 24 words in the free tail
        queue_item(make_item(CMD_ALLOC, 0, 0));
        queue_item(make_item(CMD_FREE, 0, 64));
        drain();

        write_base(16'($urandom));
        // long receiver hold-off while the sender keeps offering items
        hold_output = 1'b1;
        random_phase(300);
        drain();
        write_base(16'h8000);
        random_phase(300);
        drain();
        write_base(16'($urandom));
        random_phase(250);
        drain();
        quiet_tail = 1'b1;
        random_phase(150);
        drain();

        if (fail_count == 0)
            $display("first_fit_bitmap_allocator_top: match");
        else
            $display("first_fit_bitmap_allocator_top: mismatch");
        $finish;
    end
endmodule
